/* hdl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define NCTS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define NCTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ncts_pkg.sv */
// types, constants and command decode for the near plane strip clipper
package ncts_pkg;

    localparam int INDEX_BITS      = 16;
    localparam int DEPTH_BITS      = 32;
    localparam int LIMIT_BITS      = 31;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(65536);

    localparam logic KIND_PASS = 1'b0;
    localparam logic KIND_EDGE = 1'b1;

    typedef logic [INDEX_BITS-1:0] index_t;

    typedef struct packed {
        index_t                        vertex_index;
        logic signed [DEPTH_BITS-1:0]  vertex_depth;
        logic                          strip_first;
        logic                          strip_last;
    } in_item_t;

    typedef struct packed {
        logic   command_kind;
        index_t first_vertex;
        index_t second_vertex;
        logic   end_of_strip;
        logic   last_of_run;
    } out_item_t;

    // command sequence chosen by the front end for one vertex
    typedef enum logic [3:0] {
        OP_S_II,
        OP_S_IO,
        OP_S_OI,
        OP_C1,
        OP_C2,
        OP_C3,
        OP_C4,
        OP_C4D,
        OP_C5,
        OP_C6,
        OP_C7
    } op_t;

    typedef struct packed {
        op_t    op;
        index_t cur;
        index_t older;
        index_t newer;
        logic   eos;
    } plan_t;

    typedef struct packed {
        logic  valid;
        plan_t plan;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // number of commands a plan expands into
    function automatic logic [2:0] op_count(input op_t op);
        logic [2:0] n;
        case (op)
            OP_S_II, OP_S_IO, OP_S_OI: n = 3'd2;
            OP_C1, OP_C2, OP_C7:       n = 3'd1;
            OP_C4D:                    n = 3'd4;
            default:                   n = 3'd3;
        endcase
        return n;
    endfunction

    function automatic out_item_t mk_pass(input index_t a, input logic eos);
        out_item_t r;
        r.command_kind  = KIND_PASS;
        r.first_vertex  = a;
        r.second_vertex = '0;
        r.end_of_strip  = eos;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    function automatic out_item_t mk_edge(input index_t a, input index_t b, input logic eos);
        out_item_t r;
        r.command_kind  = KIND_EDGE;
        r.first_vertex  = a;
        r.second_vertex = b;
        r.end_of_strip  = eos;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // command at one step of a plan; last_of_run is left to the caller
    function automatic out_item_t op_cmd(input plan_t p, input logic [1:0] step);
        out_item_t r;
        r = mk_pass(p.cur, 1'b0);
        case (p.op)
            OP_S_II: r = (step == 2'd0) ? mk_pass(p.newer, 1'b0) : mk_pass(p.cur, 1'b0);
            OP_S_IO: r = (step == 2'd0) ? mk_pass(p.newer, 1'b0)
                                        : mk_edge(p.newer, p.cur, 1'b0);
            OP_S_OI: r = (step == 2'd0) ? mk_edge(p.newer, p.cur, 1'b0)
                                        : mk_pass(p.cur, 1'b0);
            OP_C1:   r = mk_edge(p.cur, p.older, 1'b1);
            OP_C2:   r = mk_edge(p.newer, p.cur, p.eos);
            OP_C3: begin
                case (step)
                    2'd0:    r = mk_edge(p.cur, p.older, 1'b0);
                    2'd1:    r = mk_pass(p.newer, 1'b0);
                    default: r = mk_edge(p.newer, p.cur, p.eos);
                endcase
            end
            OP_C4: begin
                case (step)
                    2'd0:    r = mk_edge(p.cur, p.older, 1'b0);
                    2'd1:    r = mk_edge(p.newer, p.cur, 1'b0);
                    default: r = mk_pass(p.cur, p.eos);
                endcase
            end
            OP_C4D: begin
                case (step)
                    2'd0:    r = mk_edge(p.cur, p.older, 1'b0);
                    2'd1:    r = mk_edge(p.cur, p.older, 1'b0);
                    2'd2:    r = mk_edge(p.newer, p.cur, 1'b0);
                    default: r = mk_pass(p.cur, p.eos);
                endcase
            end
            OP_C5: begin
                case (step)
                    2'd0:    r = mk_pass(p.cur, 1'b0);
                    2'd1:    r = mk_edge(p.newer, p.cur, 1'b0);
                    default: r = mk_pass(p.cur, p.eos);
                endcase
            end
            OP_C6: begin
                case (step)
                    2'd0:    r = mk_edge(p.cur, p.older, 1'b0);
                    2'd1:    r = mk_pass(p.newer, 1'b0);
                    default: r = mk_pass(p.cur, p.eos);
                endcase
            end
            OP_C7:   r = mk_pass(p.cur, p.eos);
            default: r = mk_pass(p.cur, 1'b0);
        endcase
        return r;
    endfunction

endpackage

/* hdl/ncts_front.sv */
// front end: vertex classification, strip state and command plan selection
module ncts_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ncts_pkg::in_item_t                  s_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ncts_pkg::LIMIT_BITS-1:0]     cfg_depth_limit,
    input  ncts_pkg::q_status_t                 q_status,
    output ncts_pkg::q_push_t                   q_push
);
    import ncts_pkg::*;

    localparam int CMP_BITS = (DEPTH_BITS - 1 > LIMIT_BITS) ? DEPTH_BITS - 1 : LIMIT_BITS;

    localparam logic [2:0] CODE_OLD = 3'b001;
    localparam logic [2:0] CODE_NEW = 3'b010;
    localparam logic [2:0] CODE_CUR = 3'b100;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ONE,
        PH_RUN
    } phase_t;

    logic [LIMIT_BITS-1:0] limit_reg;
    index_t                older_reg, older_next;
    index_t                newer_reg, newer_next;
    logic [1:0]            inside_reg, inside_next;
    phase_t                phase_reg, phase_next;
    logic                  odd_reg, odd_next;

    logic                  accept;
    logic                  ins;
    logic [CMP_BITS-1:0]   depth_mag;
    logic [CMP_BITS-1:0]   limit_ext;
    logic [2:0]            code;
    logic                  has_cmds;
    op_t                   op;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_status.full;
    assign accept    = s_valid && s_ready;

    // inside test: zero depth, or positive and not above the limit
    assign depth_mag = CMP_BITS'(s_item.vertex_depth[DEPTH_BITS-2:0]);
    assign limit_ext = CMP_BITS'(limit_reg);
    always_comb begin
        if (s_item.vertex_depth == '0) begin
            ins = 1'b1;
        end else if (s_item.vertex_depth[DEPTH_BITS-1]) begin
            ins = 1'b0;
        end else begin
            ins = (depth_mag <= limit_ext);
        end
    end

    assign code = {ins, inside_reg};

    // plan selection and strip state update
    always_comb begin
        has_cmds    = 1'b0;
        op          = OP_C7;
        older_next  = older_reg;
        newer_next  = newer_reg;
        inside_next = inside_reg;
        phase_next  = phase_reg;
        odd_next    = odd_reg;
        if (s_item.strip_first || phase_reg == PH_IDLE) begin
            if (s_item.strip_last) begin
                phase_next = PH_IDLE;
                odd_next   = 1'b1;
            end else begin
                newer_next  = s_item.vertex_index;
                inside_next = {1'b0, ins};
                phase_next  = PH_ONE;
                odd_next    = 1'b0;
            end
        end else if (phase_reg == PH_ONE) begin
            has_cmds = inside_reg[0] || ins;
            if (inside_reg[0] && ins) begin
                op = OP_S_II;
            end else if (inside_reg[0]) begin
                op = OP_S_IO;
            end else begin
                op = OP_S_OI;
            end
            inside_next = {ins, inside_reg[0]};
            older_next  = newer_reg;
            newer_next  = s_item.vertex_index;
            phase_next  = s_item.strip_last ? PH_IDLE : PH_RUN;
            odd_next    = 1'b1;
        end else begin
            has_cmds = (code != 3'b000);
            case (code)
                CODE_OLD:                       op = OP_C1;
                CODE_NEW:                       op = OP_C2;
                CODE_OLD | CODE_NEW:            op = OP_C3;
                CODE_CUR:                       op = odd_reg ? OP_C4 : OP_C4D;
                CODE_CUR | CODE_OLD:            op = OP_C5;
                CODE_CUR | CODE_NEW:            op = OP_C6;
                CODE_CUR | CODE_NEW | CODE_OLD: op = OP_C7;
                default:                        op = OP_C7;
            endcase
            inside_next = code[2:1];
            older_next  = newer_reg;
            newer_next  = s_item.vertex_index;
            if (s_item.strip_last) begin
                phase_next = PH_IDLE;
                odd_next   = 1'b1;
            end else begin
                odd_next   = !odd_reg;
            end
        end
    end

    // push toward the back end
    always_comb begin
        q_push.valid      = accept && has_cmds;
        q_push.plan.op    = op;
        q_push.plan.cur   = s_item.vertex_index;
        q_push.plan.older = older_reg;
        q_push.plan.newer = newer_reg;
        q_push.plan.eos   = s_item.strip_last;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg  <= LIMIT_RESET;
            older_reg  <= '0;
            newer_reg  <= '0;
            inside_reg <= '0;
            phase_reg  <= PH_IDLE;
            odd_reg    <= 1'b1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_depth_limit;
            end
            if (accept) begin
                older_reg  <= older_next;
                newer_reg  <= newer_next;
                inside_reg <= inside_next;
                phase_reg  <= phase_next;
                odd_reg    <= odd_next;
            end
        end
    end

endmodule

/* hdl/ncts_queue.sv */
// plan queue between front and back end
module ncts_queue #(
    parameter int DEPTH = ncts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ncts_pkg::q_push_t     q_push,
    input  logic                  pop,
    output ncts_pkg::q_status_t   q_status,
    output ncts_pkg::plan_t       head
);
    import ncts_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    plan_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = q_push.valid && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = entry_reg[rd_ptr_reg];

    // pointer wrap for any depth
    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= q_push.plan;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* hdl/ncts_back.sv */
// back end: expands plans into commands through the output register
module ncts_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ncts_pkg::q_status_t   q_status,
    input  ncts_pkg::plan_t       head,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ncts_pkg::out_item_t   m_item
);
    import ncts_pkg::*;

    logic [1:0]  step_reg;
    logic        m_valid_reg;
    out_item_t   m_item_reg;
    out_item_t   cmd;
    logic        load;
    logic        at_last;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // current command of the head plan
    assign load    = !q_status.empty && (!m_valid_reg || m_ready);
    assign at_last = ({1'b0, step_reg} == op_count(head.op) - 3'd1);
    assign pop     = load && at_last;

    always_comb begin
        cmd             = op_cmd(head, step_reg);
        cmd.last_of_run = at_last;
    end

    // output payload register
    always_ff @(posedge aclk) begin
        if (load) begin
            m_item_reg <= cmd;
        end
    end

    // output valid and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                step_reg    <= at_last ? 2'd0 : step_reg + 2'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hdl/near_clip_triangle_strip.sv */
// top level of the near plane triangle strip clipper
//
//  channel   dir  handshake              payload
//  s_        in   s_valid / s_ready      in_item_t: one strip vertex
//  m_        out  m_valid / m_ready      out_item_t: one command
//  cfg_      in   cfg_valid / cfg_ready  depth limit, unsigned Q15.16
//
// a vertex is taken every cycle while the plan queue has room; it leaves
// 0 to 4 commands, sent one per cycle from the output register while
// m_ready is high, so the result port sets the sustained vertex rate
// the first command of a vertex passes the plan queue entry, then the output register
// reset is synchronous, active low, and empties the queue; cfg_ready is always high
// m_ready low stalls only the back end until the QUEUE_DEPTH plan queue fills
module near_clip_triangle_strip #(
    parameter int QUEUE_DEPTH = ncts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ncts_pkg::in_item_t                s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ncts_pkg::out_item_t               m_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ncts_pkg::LIMIT_BITS-1:0]   cfg_depth_limit
);
    import ncts_pkg::*;

    q_push_t   q_push;
    q_status_t q_status;
    plan_t     head;
    logic      pop;

    // classification and strip state
    ncts_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_depth_limit (cfg_depth_limit),
        .q_status        (q_status),
        .q_push          (q_push)
    );

    // decoupling queue
    ncts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_push   (q_push),
        .pop      (pop),
        .q_status (q_status),
        .head     (head)
    );

    // command expansion
    ncts_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

/* hdl/ncts_checker.sv */
// port level checks for the strip clipper, bound to the top level
`include "assert_macros.svh"

module ncts_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input ncts_pkg::out_item_t   m_item
);
    import ncts_pkg::*;

    // a stalled request stays up
    `NCTS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "m_valid dropped while stalled")

    // a stalled request keeps its payload
    `NCTS_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_item), "m_item changed while stalled")

    // pass-through commands carry no second vertex
    `NCTS_ASSERT_ALWAYS(a_pass_zero, !m_valid || m_item.command_kind != KIND_PASS || m_item.second_vertex == '0, "pass command with nonzero second vertex")

    // an end of strip command always closes its vertex's run
    `NCTS_ASSERT_ALWAYS(a_eos_last, !m_valid || !m_item.end_of_strip || m_item.last_of_run, "end of strip before last command of run")

endmodule

bind near_clip_triangle_strip ncts_checker u_ncts_checker (.*);
